/* src/adaptive_transfer_size_selector_defines.svh */
// Assertion macros for the adaptive transfer size selector.
// Expects clk and rst_n in the scope of the including module.
`ifndef ADAPTIVE_TRANSFER_SIZE_SELECTOR_DEFINES_SVH
`define ADAPTIVE_TRANSFER_SIZE_SELECTOR_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define ATSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define ATSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/atss_pkg.sv */
// Shared types, constants and helpers of the adaptive transfer size selector.
// No dependencies.
package atss_pkg;

    localparam int UNIT_LOG_DEF     = 10;
    localparam int BUCKETS_DEF      = 64;
    localparam int TERM_HITS_DEF    = 16;
    localparam int FRACTION_LOG_DEF = 6;

    localparam int SIZE_W     = 24;
    localparam int TIME_W     = 40;
    localparam int THR_W      = 32;
    localparam int ACC_W      = 64;
    localparam int HIT_W      = 32;
    localparam int LOG_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    localparam int MSEC_SHIFT = 13;
    localparam int SEC_SHIFT  = 23;

    localparam logic [SIZE_W-1:0] SIZE_MAX = 24'hFFFFFF;

    localparam logic [THR_W-1:0]  DEF_THROUGHPUT_RST = 32'd1048576;
    localparam logic [TIME_W-1:0] SLOW_TERM_RST      = 40'd1000000;
    localparam logic [SIZE_W-1:0] STEP_BACK_RST      = 24'd24576;
    localparam logic [SIZE_W-1:0] RAISED_MIN_RST     = 24'd8192;
    localparam logic [ACC_W-1:0]  BUCKET_TIME_INIT   = 64'd10000000;

    typedef enum logic [0:0] {
        CMD_CHOOSE = 1'b0,
        CMD_UPDATE = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEF_THROUGHPUT = 3'd0,
        CFG_SLOW_TERM      = 3'd1,
        CFG_STEP_BACK      = 3'd2,
        CFG_RAISED_MIN     = 3'd3
    } cfg_idx_t;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_CHS   = 10'b00_0000_0100,
        S_SCAN  = 10'b00_0000_1000,
        S_OUT   = 10'b00_0001_0000,
        S_UPD   = 10'b00_0010_0000,
        S_UPT   = 10'b00_0100_0000,
        S_WRATE = 10'b00_1000_0000,
        S_NUDGE = 10'b01_0000_0000,
        S_ORATE = 10'b10_0000_0000
    } state_t;

    // Position of the highest set bit; zero for zero and one.
    function automatic logic [LOG_W-1:0] floor_log2(input logic [ACC_W-1:0] v);
        logic [LOG_W-1:0] n;
        n = '0;
        for (int i = 1; i < ACC_W; i++) begin
            if (v[i])
            begin
                n = LOG_W'(i);
            end
        end
        return n;
    endfunction

    function automatic logic [ACC_W-1:0] sat_sub(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        return (a >= b) ? (a - b) : '0;
    endfunction

endpackage

/* src/adaptive_transfer_size_selector.sv */
// Adaptive transfer size selector: top level, sequencer, bucket and term memories.
// Depends on atss_pkg and adaptive_transfer_size_selector_defines.svh.
//
// Use: each input transfer carries a command. A choose transfer (command 0)
// returns one transfer_size on the output channel; an update transfer
// (command 1) folds a finished transfer into the statistics and returns none.
// Both channels use valid/ready; in_ready is high only while idle.
// Timing: a choose answered directly (below the minimum or from the cache)
// goes from the check state to the output state, which loads the answer. A
// scanning choose streams n buckets through the shared rate unit (read, log2,
// shift), one per cycle, and loads the answer after the last result, n at most BUCKETS.
// The input is ready again at the edge that loads the answer. An update frees
// the input once its term is written, or at once if dropped; every 2^FRACTION_LOG-th
// update that is not dropped first sweeps all BUCKETS buckets through the same rate unit.
// Reset: control and statistics return to their reset values, then a clearing
// pass over all BUCKETS entries initializes the bucket and term memories; no
// input is taken meanwhile. Configuration writes are taken at any time.
// Stall: a finished answer sits in the output register; the block still takes
// and works the next transfer, and only holds before loading a new answer.
`include "adaptive_transfer_size_selector_defines.svh"

module adaptive_transfer_size_selector #(
    parameter int UNIT_LOG     = atss_pkg::UNIT_LOG_DEF,
    parameter int BUCKETS      = atss_pkg::BUCKETS_DEF,
    parameter int TERM_HITS    = atss_pkg::TERM_HITS_DEF,
    parameter int FRACTION_LOG = atss_pkg::FRACTION_LOG_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [atss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [atss_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 command,
    input  logic [atss_pkg::SIZE_W-1:0]          io_size,
    input  logic [atss_pkg::SIZE_W-1:0]          unit_io_size,
    input  logic [atss_pkg::SIZE_W-1:0]          total_io_size,
    input  logic [atss_pkg::TIME_W-1:0]          elapsed_time,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [atss_pkg::SIZE_W-1:0]          transfer_size
);

    localparam int IDXW = $clog2(BUCKETS);
    localparam int CNTW = IDXW + 1;
    localparam int RESW = (TERM_HITS > 1) ? $clog2(TERM_HITS) : 1;
    localparam int SZW  = IDXW + 1 + UNIT_LOG;
    localparam int AW   = atss_pkg::ACC_W;
    localparam int SW   = atss_pkg::SIZE_W;

    localparam logic [AW-1:0] BYTES_INIT = AW'(atss_pkg::DEF_THROUGHPUT_RST);
    localparam logic [AW-1:0] OVERALL_BYTES_INIT = AW'(BUCKETS) * BYTES_INIT;
    localparam logic [AW-1:0] OVERALL_TIME_INIT =
        AW'(BUCKETS) * atss_pkg::BUCKET_TIME_INIT;

    // chunk size of a bucket, saturated to the field width
    function automatic logic [SW-1:0] size_of(input logic [IDXW-1:0] idx);
        logic [SZW-1:0] s;
        s = (SZW'(idx) + SZW'(1)) << UNIT_LOG;
        return (32'(s) > 32'(atss_pkg::SIZE_MAX)) ? atss_pkg::SIZE_MAX : SW'(s);
    endfunction

    atss_pkg::state_t state_reg, state_next;

    // configuration
    logic [atss_pkg::THR_W-1:0]  def_thr_reg;
    logic [atss_pkg::TIME_W-1:0] slow_term_reg;
    logic [SW-1:0]               step_back_reg;
    logic [SW-1:0]               raised_min_reg;

    // latched request
    logic [SW-1:0]               req_reg, req_next;
    logic [SW-1:0]               unit_reg, unit_next;
    logic [SW-1:0]               total_reg, total_next;
    logic [atss_pkg::TIME_W-1:0] elapsed_reg, elapsed_next;

    // scalar statistics
    logic [AW-1:0]               overall_bytes_reg, overall_bytes_next;
    logic [AW-1:0]               overall_time_reg, overall_time_next;
    logic [AW-1:0]               window_bytes_reg, window_bytes_next;
    logic [AW-1:0]               window_time_reg, window_time_next;
    logic [atss_pkg::HIT_W-1:0]  update_count_reg, update_count_next;
    logic [SW-1:0]               last_req_reg, last_req_next;
    logic [IDXW-1:0]             last_choice_reg, last_choice_next;
    logic [IDXW-1:0]             min_idx_reg, min_idx_next;

    // sequencer working state
    logic [CNTW-1:0]             cnt_reg, cnt_next;
    logic [CNTW-1:0]             lim_reg, lim_next;
    logic                        issuing_reg, issuing_next;
    logic                        first_reg, first_next;
    logic [IDXW-1:0]             best_reg, best_next;
    logic [AW-1:0]               best_rate_reg, best_rate_next;
    logic [IDXW-1:0]             bidx_reg, bidx_next;
    logic [AW-1:0]               wrate_reg, wrate_next;
    logic [SW-1:0]               res_reg, res_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [SW-1:0]               transfer_size_reg, transfer_size_next;

    // rate unit: issue, log2 and shift stages
    logic                        iss_valid_reg, iss_valid_next;
    logic                        iss_mem_reg, iss_mem_next;
    logic                        iss_sec_reg, iss_sec_next;
    logic                        iss_last_reg, iss_last_next;
    logic [IDXW-1:0]             iss_idx_reg, iss_idx_next;
    logic [AW-1:0]               iss_bytes_reg, iss_bytes_next;
    logic [AW-1:0]               iss_time_reg, iss_time_next;

    logic                        s1_valid_reg, s1_last_reg;
    logic [IDXW-1:0]             s1_idx_reg;
    logic [atss_pkg::LOG_W-1:0]  s1_log_reg;
    logic [AW-1:0]               s1_bytes_reg, s1_time_reg;

    logic                        s2_valid_reg, s2_last_reg;
    logic [IDXW-1:0]             s2_idx_reg;
    logic [AW-1:0]               s2_rate_reg, s2_bytes_reg, s2_time_reg;

    logic [AW-1:0]               src_bytes, src_time, src_shifted;

    // memories
    logic [AW-1:0]               bkt_bytes_mem [BUCKETS];
    logic [AW-1:0]               bkt_time_mem  [BUCKETS];
    logic [AW-1:0]               term_bytes_mem[BUCKETS];
    logic [AW-1:0]               term_time_mem [BUCKETS];
    logic [atss_pkg::HIT_W-1:0]  hit_mem       [BUCKETS];
    logic [RESW-1:0]             res_mem       [BUCKETS];

    logic [IDXW-1:0]             rd_addr;
    logic [AW-1:0]               bkt_rd_bytes_reg, bkt_rd_time_reg;
    logic [AW-1:0]               term_rd_bytes_reg, term_rd_time_reg;
    logic [atss_pkg::HIT_W-1:0]  term_rd_hit_reg;
    logic [RESW-1:0]             term_rd_res_reg;

    logic                        bkt_we, term_we;
    logic [IDXW-1:0]             bkt_wa, term_wa;
    logic [AW-1:0]               bkt_wbytes, bkt_wtime, term_wbytes, term_wtime;
    logic [atss_pkg::HIT_W-1:0]  term_whit;
    logic [RESW-1:0]             term_wres;

    logic                        accept;
    logic [31:0]                 min_size;

    assign in_ready      = (state_reg == atss_pkg::S_IDLE);
    assign accept        = in_valid && in_ready;
    assign out_valid     = out_valid_reg;
    assign transfer_size = transfer_size_reg;
    // smallest request size that is not passed straight through
    assign min_size      = (32'(min_idx_reg) + 32'd1) << UNIT_LOG;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        logic [SW-1:0]              q;
        logic [CNTW-1:0]            lim_calc;
        logic [IDXW-1:0]            start;
        logic [IDXW-1:0]            fin_best;
        logic [AW-1:0]              tb, tt, db, dt, ob, ot;
        logic [atss_pkg::HIT_W-1:0] hc;
        logic [RESW-1:0]            rn;
        logic                       commit_hit, slow;

        state_next         = state_reg;
        req_next           = req_reg;
        unit_next          = unit_reg;
        total_next         = total_reg;
        elapsed_next       = elapsed_reg;
        overall_bytes_next = overall_bytes_reg;
        overall_time_next  = overall_time_reg;
        window_bytes_next  = window_bytes_reg;
        window_time_next   = window_time_reg;
        update_count_next  = update_count_reg;
        last_req_next      = last_req_reg;
        last_choice_next   = last_choice_reg;
        min_idx_next       = min_idx_reg;
        cnt_next           = cnt_reg;
        lim_next           = lim_reg;
        issuing_next       = issuing_reg;
        first_next         = first_reg;
        best_next          = best_reg;
        best_rate_next     = best_rate_reg;
        bidx_next          = bidx_reg;
        wrate_next         = wrate_reg;
        res_next           = res_reg;

        out_valid_next     = out_valid_reg && !out_ready;
        transfer_size_next = transfer_size_reg;

        rd_addr        = cnt_reg[IDXW-1:0];
        iss_valid_next = 1'b0;
        iss_mem_next   = 1'b1;
        iss_sec_next   = 1'b0;
        iss_last_next  = 1'b0;
        iss_idx_next   = cnt_reg[IDXW-1:0];
        iss_bytes_next = window_bytes_reg;
        iss_time_next  = window_time_reg;

        bkt_we      = 1'b0;
        bkt_wa      = cnt_reg[IDXW-1:0];
        bkt_wbytes  = BYTES_INIT;
        bkt_wtime   = atss_pkg::BUCKET_TIME_INIT;
        term_we     = 1'b0;
        term_wa     = cnt_reg[IDXW-1:0];
        term_wbytes = '0;
        term_wtime  = '0;
        term_whit   = '0;
        term_wres   = '0;

        q        = req_reg >> UNIT_LOG;
        lim_calc = (32'(q) > 32'(BUCKETS)) ? CNTW'(BUCKETS - 1) : CNTW'(q - SW'(1));
        start    = (last_req_reg != '0) ? last_choice_reg : min_idx_reg;
        fin_best = best_reg;

        tb = term_rd_bytes_reg + AW'(total_reg);
        tt = term_rd_time_reg + AW'(elapsed_reg);
        hc = term_rd_hit_reg + 32'd1;
        // hit count modulo TERM_HITS, restarted when the count wraps
        if (hc == '0)
        begin
            rn = '0;
        end
        else if (32'(term_rd_res_reg) + 32'd1 == 32'(TERM_HITS))
        begin
            rn = '0;
        end
        else
        begin
            rn = RESW'(32'(term_rd_res_reg) + 32'd1);
        end
        commit_hit = (rn == '0);
        slow       = (tt >= AW'(slow_term_reg));

        db = window_bytes_reg >> FRACTION_LOG;
        dt = window_time_reg >> FRACTION_LOG;
        ob = overall_bytes_reg + window_bytes_reg;
        ot = overall_time_reg + window_time_reg;

        unique case (state_reg)
            atss_pkg::S_CLEAR:
            begin
                bkt_we   = 1'b1;
                term_we  = 1'b1;
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(BUCKETS - 1))
                begin
                    state_next = atss_pkg::S_IDLE;
                end
            end

            atss_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    req_next     = io_size;
                    unit_next    = unit_io_size;
                    total_next   = total_io_size;
                    elapsed_next = elapsed_time;
                    state_next   = (command == atss_pkg::CMD_CHOOSE) ?
                                   atss_pkg::S_CHS : atss_pkg::S_UPD;
                end
            end

            atss_pkg::S_CHS:
            begin
                if (32'(req_reg) < min_size)
                begin
                    // small request passes through
                    res_next   = req_reg;
                    state_next = atss_pkg::S_OUT;
                end
                else if (last_req_reg != '0 && last_req_reg >= req_reg)
                begin
                    // cached choice still covers the request
                    res_next   = size_of(last_choice_reg);
                    state_next = atss_pkg::S_OUT;
                end
                else
                begin
                    // scan: first the current best, then upward to the limit
                    best_next    = start;
                    cnt_next     = CNTW'(start);
                    lim_next     = (lim_calc < CNTW'(start)) ? CNTW'(start) : lim_calc;
                    first_next   = 1'b1;
                    issuing_next = 1'b1;
                    state_next   = atss_pkg::S_SCAN;
                end
            end

            atss_pkg::S_SCAN:
            begin
                if (issuing_reg)
                begin
                    iss_valid_next = 1'b1;
                    iss_last_next  = (cnt_reg == lim_reg);
                    cnt_next       = cnt_reg + CNTW'(1);
                    if (cnt_reg == lim_reg)
                    begin
                        issuing_next = 1'b0;
                    end
                end
                if (s2_valid_reg)
                begin
                    if (first_reg)
                    begin
                        best_rate_next = s2_rate_reg;
                        first_next     = 1'b0;
                    end
                    else if (s2_rate_reg >= best_rate_reg)
                    begin
                        best_next      = s2_idx_reg;
                        best_rate_next = s2_rate_reg;
                        fin_best       = s2_idx_reg;
                    end
                    if (s2_last_reg)
                    begin
                        last_req_next    = req_reg;
                        last_choice_next = fin_best;
                        res_next         = size_of(fin_best);
                        state_next       = atss_pkg::S_OUT;
                    end
                end
            end

            atss_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next     = 1'b1;
                    transfer_size_next = res_reg;
                    state_next         = atss_pkg::S_IDLE;
                end
            end

            atss_pkg::S_UPD:
            begin
                rd_addr = IDXW'((unit_reg >> UNIT_LOG) - SW'(1));
                if (32'(unit_reg) < min_size ||
                    32'(unit_reg >> UNIT_LOG) > 32'(BUCKETS))
                begin
                    state_next = atss_pkg::S_IDLE;
                end
                else
                begin
                    window_bytes_next = window_bytes_reg + AW'(total_reg);
                    window_time_next  = window_time_reg + AW'(elapsed_reg);
                    update_count_next = update_count_reg + 32'd1;
                    bidx_next         = rd_addr;
                    state_next        = atss_pkg::S_UPT;
                end
            end

            atss_pkg::S_UPT:
            begin
                term_we   = 1'b1;
                term_wa   = bidx_reg;
                term_whit = hc;
                term_wres = rn;
                bkt_wa    = bidx_reg;
                if (commit_hit || slow)
                begin
                    bkt_we     = 1'b1;
                    bkt_wbytes = bkt_rd_bytes_reg + tb;
                    bkt_wtime  = bkt_rd_time_reg + tt;
                end
                else
                begin
                    term_wbytes = tb;
                    term_wtime  = tt;
                end
                if (commit_hit)
                begin
                    last_req_next = '0;
                end
                else if (slow)
                begin
                    // slow term: step back two buckets, or drop the cache
                    if (32'(size_of(last_choice_reg)) >= 32'(step_back_reg))
                    begin
                        last_choice_next = (last_choice_reg >= IDXW'(2)) ?
                                           last_choice_reg - IDXW'(2) : '0;
                    end
                    else
                    begin
                        last_req_next = '0;
                    end
                end
                if (update_count_reg[FRACTION_LOG-1:0] == '0)
                begin
                    iss_valid_next = 1'b1;
                    iss_mem_next   = 1'b0;
                    iss_last_next  = 1'b1;
                    state_next     = atss_pkg::S_WRATE;
                end
                else
                begin
                    state_next = atss_pkg::S_IDLE;
                end
            end

            atss_pkg::S_WRATE:
            begin
                if (s2_valid_reg)
                begin
                    wrate_next   = s2_rate_reg;
                    cnt_next     = '0;
                    issuing_next = 1'b1;
                    state_next   = atss_pkg::S_NUDGE;
                end
            end

            atss_pkg::S_NUDGE:
            begin
                if (issuing_reg)
                begin
                    iss_valid_next = 1'b1;
                    iss_last_next  = (cnt_reg == CNTW'(BUCKETS - 1));
                    cnt_next       = cnt_reg + CNTW'(1);
                    if (cnt_reg == CNTW'(BUCKETS - 1))
                    begin
                        issuing_next = 1'b0;
                    end
                end
                if (s2_valid_reg)
                begin
                    // pull each bucket toward the window average
                    bkt_we = 1'b1;
                    bkt_wa = s2_idx_reg;
                    if (s2_rate_reg >= wrate_reg)
                    begin
                        bkt_wbytes = atss_pkg::sat_sub(s2_bytes_reg, db);
                        bkt_wtime  = atss_pkg::sat_sub(s2_time_reg, dt);
                    end
                    else
                    begin
                        bkt_wbytes = s2_bytes_reg + db;
                        bkt_wtime  = s2_time_reg + dt;
                    end
                    if (s2_last_reg)
                    begin
                        overall_bytes_next = ob;
                        overall_time_next  = ot;
                        window_bytes_next  = '0;
                        window_time_next   = '0;
                        last_req_next      = '0;
                        iss_valid_next     = 1'b1;
                        iss_mem_next       = 1'b0;
                        iss_sec_next       = 1'b1;
                        iss_last_next      = 1'b1;
                        iss_bytes_next     = ob;
                        iss_time_next      = ot;
                        state_next         = atss_pkg::S_ORATE;
                    end
                end
            end

            atss_pkg::S_ORATE:
            begin
                if (s2_valid_reg)
                begin
                    if (s2_rate_reg <= AW'(def_thr_reg))
                    begin
                        min_idx_next = '0;
                    end
                    else if (32'(raised_min_reg >> UNIT_LOG) >= 32'(BUCKETS))
                    begin
                        min_idx_next = IDXW'(BUCKETS - 1);
                    end
                    else
                    begin
                        min_idx_next = IDXW'(raised_min_reg >> UNIT_LOG);
                    end
                    state_next = atss_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = atss_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Rate unit source: memory read data or a scalar pair
    // ---------------------------------------------------------------
    assign src_bytes   = iss_mem_reg ? bkt_rd_bytes_reg : iss_bytes_reg;
    assign src_time    = iss_mem_reg ? bkt_rd_time_reg : iss_time_reg;
    assign src_shifted = iss_sec_reg ? (src_time >> atss_pkg::SEC_SHIFT)
                                     : (src_time >> atss_pkg::MSEC_SHIFT);

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= atss_pkg::S_CLEAR;
            cnt_reg           <= '0;
            issuing_reg       <= 1'b0;
            first_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
            iss_valid_reg     <= 1'b0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            overall_bytes_reg <= OVERALL_BYTES_INIT;
            overall_time_reg  <= OVERALL_TIME_INIT;
            window_bytes_reg  <= '0;
            window_time_reg   <= '0;
            update_count_reg  <= '0;
            last_req_reg      <= '0;
            last_choice_reg   <= '0;
            min_idx_reg       <= '0;
            def_thr_reg       <= atss_pkg::DEF_THROUGHPUT_RST;
            slow_term_reg     <= atss_pkg::SLOW_TERM_RST;
            step_back_reg     <= atss_pkg::STEP_BACK_RST;
            raised_min_reg    <= atss_pkg::RAISED_MIN_RST;
        end
        else
        begin
            state_reg         <= state_next;
            cnt_reg           <= cnt_next;
            issuing_reg       <= issuing_next;
            first_reg         <= first_next;
            out_valid_reg     <= out_valid_next;
            iss_valid_reg     <= iss_valid_next;
            s1_valid_reg      <= iss_valid_reg;
            s2_valid_reg      <= s1_valid_reg;
            overall_bytes_reg <= overall_bytes_next;
            overall_time_reg  <= overall_time_next;
            window_bytes_reg  <= window_bytes_next;
            window_time_reg   <= window_time_next;
            update_count_reg  <= update_count_next;
            last_req_reg      <= last_req_next;
            last_choice_reg   <= last_choice_next;
            min_idx_reg       <= min_idx_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    atss_pkg::CFG_DEF_THROUGHPUT:
                        def_thr_reg <= cfg_data[atss_pkg::THR_W-1:0];
                    atss_pkg::CFG_SLOW_TERM:
                        slow_term_reg <= cfg_data[atss_pkg::TIME_W-1:0];
                    atss_pkg::CFG_STEP_BACK:
                        step_back_reg <= cfg_data[SW-1:0];
                    atss_pkg::CFG_RAISED_MIN:
                        raised_min_reg <= cfg_data[SW-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        req_reg           <= req_next;
        unit_reg          <= unit_next;
        total_reg         <= total_next;
        elapsed_reg       <= elapsed_next;
        lim_reg           <= lim_next;
        best_reg          <= best_next;
        best_rate_reg     <= best_rate_next;
        bidx_reg          <= bidx_next;
        wrate_reg         <= wrate_next;
        res_reg           <= res_next;
        transfer_size_reg <= transfer_size_next;

        iss_mem_reg       <= iss_mem_next;
        iss_sec_reg       <= iss_sec_next;
        iss_last_reg      <= iss_last_next;
        iss_idx_reg       <= iss_idx_next;
        iss_bytes_reg     <= iss_bytes_next;
        iss_time_reg      <= iss_time_next;

        s1_last_reg       <= iss_last_reg;
        s1_idx_reg        <= iss_idx_reg;
        s1_log_reg        <= atss_pkg::floor_log2(src_shifted);
        s1_bytes_reg      <= src_bytes;
        s1_time_reg       <= src_time;

        s2_last_reg       <= s1_last_reg;
        s2_idx_reg        <= s1_idx_reg;
        s2_rate_reg       <= s1_bytes_reg >> s1_log_reg;
        s2_bytes_reg      <= s1_bytes_reg;
        s2_time_reg       <= s1_time_reg;
    end

    // ---------------------------------------------------------------
    // Bucket and term memories: one write, one registered read
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            bkt_bytes_mem[bkt_wa] <= bkt_wbytes;
            bkt_time_mem[bkt_wa]  <= bkt_wtime;
        end
        bkt_rd_bytes_reg <= bkt_bytes_mem[rd_addr];
        bkt_rd_time_reg  <= bkt_time_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (term_we)
        begin
            term_bytes_mem[term_wa] <= term_wbytes;
            term_time_mem[term_wa]  <= term_wtime;
            hit_mem[term_wa]        <= term_whit;
            res_mem[term_wa]        <= term_wres;
        end
        term_rd_bytes_reg <= term_bytes_mem[rd_addr];
        term_rd_time_reg  <= term_time_mem[rd_addr];
        term_rd_hit_reg   <= hit_mem[rd_addr];
        term_rd_res_reg   <= res_mem[rd_addr];
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ATSS_ASSERT_NXT(a_busy_after_accept, accept, state_reg != atss_pkg::S_IDLE,
        "block idle right after taking a transfer")
    `ATSS_ASSERT_IMP(a_idle_pipe_empty, state_reg == atss_pkg::S_IDLE,
        !s1_valid_reg && !s2_valid_reg, "rate unit busy while idle")
    `ATSS_ASSERT_IMP(a_scan_ascending,
        state_reg == atss_pkg::S_SCAN && s2_valid_reg && !first_reg,
        s2_idx_reg > best_reg, "scan result not above current best")
    `ATSS_ASSERT_IMP(a_out_from_out_state, $rose(out_valid_reg),
        $past(state_reg) == atss_pkg::S_OUT, "answer loaded outside output state")

endmodule

/* tb/tb_adaptive_transfer_size_selector.sv */
// Self-checking testbench for adaptive_transfer_size_selector: directed and random choose/update
// transfers, checked against an in-bench model of the bucket statistics.
// Depends on atss_pkg and the adaptive_transfer_size_selector RTL.
module tb_adaptive_transfer_size_selector;
    import atss_pkg::*;

    localparam int UNIT       = UNIT_LOG_DEF;
    localparam int NBUCKET    = BUCKETS_DEF;
    localparam int HITS       = TERM_HITS_DEF;
    localparam int FRAC       = FRACTION_LOG_DEF;
    localparam int CYCLE_CAP  = 2000000;
    localparam int DRAIN_WAIT = NBUCKET + 40;   // longest internal sweep plus margin
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(5);  // no register here

    typedef struct {
        cmd_t               cmd;
        logic [SIZE_W-1:0]  io;
        logic [SIZE_W-1:0]  unit;
        logic [SIZE_W-1:0]  total;
        logic [TIME_W-1:0]  elapsed;
    } xfer_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   command;
    logic [SIZE_W-1:0]      io_size;
    logic [SIZE_W-1:0]      unit_io_size;
    logic [SIZE_W-1:0]      total_io_size;
    logic [TIME_W-1:0]      elapsed_time;
    logic                   out_valid;
    logic                   out_ready;
    logic [SIZE_W-1:0]      transfer_size;

    adaptive_transfer_size_selector DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .io_size(io_size), .unit_io_size(unit_io_size),
        .total_io_size(total_io_size), .elapsed_time(elapsed_time),
        .out_valid(out_valid), .out_ready(out_ready), .transfer_size(transfer_size)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    xfer_t              pending_xfers[$];   // fed to the driver
    logic [SIZE_W-1:0]  chosen_sizes[$];    // predicted answers, oldest first
    int                 mismatches = 0;
    int                 cycles = 0;
    bit                 in_taken = 0;
    bit                 quiet_mode = 0;     // no idling on either side
    bit                 long_hold_req = 0;  // receiver long hold-off request
    int                 send_gap = 0;
    int                 recv_stall = 0;
    int                 recv_hold = 0;

    // Shadow of the block's statistics and configuration
    logic [THR_W-1:0]   m_default_tp;
    logic [TIME_W-1:0]  m_slow_term;
    logic [SIZE_W-1:0]  m_step_back;
    logic [SIZE_W-1:0]  m_raised_min;
    logic [ACC_W-1:0]   bkt_bytes[NBUCKET];
    logic [ACC_W-1:0]   bkt_time[NBUCKET];
    logic [ACC_W-1:0]   trm_bytes[NBUCKET];
    logic [ACC_W-1:0]   trm_time[NBUCKET];
    logic [HIT_W-1:0]   hits[NBUCKET];
    logic [ACC_W-1:0]   tot_bytes, tot_time, win_bytes, win_time;
    logic [31:0]        upd_count;
    logic [SIZE_W-1:0]  cached_req;
    logic [LOG_W-1:0]   cached_idx;
    logic [LOG_W-1:0]   min_idx;

    // ------------------------------------------------------------------
    // Throughput model
    // ------------------------------------------------------------------
    function automatic int top_bit(input logic [ACC_W-1:0] v);
        for (int i = ACC_W - 1; i > 0; i--)
        begin
            if (v[i])
                return i;
        end
        return 0;   // zero and one both give zero
    endfunction

    function automatic logic [ACC_W-1:0] est_rate(input logic [ACC_W-1:0] bytes,
                                                  input logic [ACC_W-1:0] t, input int sh);
        return bytes >> top_bit(t >> sh);
    endfunction

    function automatic logic [SIZE_W-1:0] chunk_of(input logic [LOG_W-1:0] idx);
        logic [31:0] s;
        s = (32'(idx) + 1) << UNIT;
        return (s > 32'(SIZE_MAX)) ? SIZE_MAX : s[SIZE_W-1:0];
    endfunction

    function automatic void stats_reset();
        m_default_tp = DEF_THROUGHPUT_RST;
        m_slow_term  = SLOW_TERM_RST;
        m_step_back  = STEP_BACK_RST;
        m_raised_min = RAISED_MIN_RST;
        for (int i = 0; i < NBUCKET; i++)
        begin
            bkt_bytes[i] = 64'(DEF_THROUGHPUT_RST);
            bkt_time[i]  = BUCKET_TIME_INIT;
            trm_bytes[i] = '0;
            trm_time[i]  = '0;
            hits[i]      = '0;
        end
        tot_bytes  = 64'(NBUCKET) * 64'(DEF_THROUGHPUT_RST);
        tot_time   = 64'(NBUCKET) * BUCKET_TIME_INIT;
        win_bytes  = '0;
        win_time   = '0;
        upd_count  = '0;
        cached_req = '0;
        cached_idx = '0;
        min_idx    = '0;
    endfunction

    function automatic logic [SIZE_W-1:0] choose_size(input logic [SIZE_W-1:0] req);
        logic [LOG_W-1:0] best;
        best = min_idx;
        // below the minimum chunk: request goes through as is
        if (32'(req) < ((32'(min_idx) + 1) << UNIT))
            return req;
        if (cached_req != 0)
        begin
            if (cached_req >= req)
                return chunk_of(cached_idx);
            best = cached_idx;
        end
        for (int idx = int'(best) + 1; idx < NBUCKET; idx++)
        begin
            if (32'(req) < (32'(idx + 1) << UNIT))
                break;
            if (est_rate(bkt_bytes[idx], bkt_time[idx], MSEC_SHIFT) >=
                est_rate(bkt_bytes[best], bkt_time[best], MSEC_SHIFT))
                best = LOG_W'(idx);
        end
        cached_req = req;
        cached_idx = best;
        return chunk_of(best);
    endfunction

    function automatic void close_term(input int b);
        bkt_bytes[b] += trm_bytes[b];
        bkt_time[b]  += trm_time[b];
        trm_bytes[b] = '0;
        trm_time[b]  = '0;
    endfunction

    function automatic void fold_update(input logic [SIZE_W-1:0] unit,
                                        input logic [SIZE_W-1:0] total,
                                        input logic [TIME_W-1:0] elapsed);
        logic [ACC_W-1:0] wrate, db, dt;
        logic [SIZE_W-1:0] m;
        int b;
        // small transfers and out-of-range buckets are dropped
        if (32'(unit) < ((32'(min_idx) + 1) << UNIT))
            return;
        b = int'(unit >> UNIT) - 1;
        if (b >= NBUCKET)
            return;
        win_bytes += 64'(total);
        win_time  += 64'(elapsed);
        upd_count += 1;
        trm_bytes[b] += 64'(total);
        trm_time[b]  += 64'(elapsed);
        hits[b] += 1;
        if (hits[b] % HITS == 0)
        begin
            cached_req = '0;
            close_term(b);
        end
        else if (trm_time[b] >= 64'(m_slow_term))
        begin
            // slow term: large cached choice steps back, small one is dropped
            if (chunk_of(cached_idx) >= m_step_back)
                cached_idx = (cached_idx >= LOG_W'(2)) ? cached_idx - LOG_W'(2) : '0;
            else
                cached_req = '0;
            close_term(b);
        end
        if (upd_count[FRAC-1:0] == 0)
        begin
            wrate = est_rate(win_bytes, win_time, MSEC_SHIFT);
            db = win_bytes >> FRAC;
            dt = win_time >> FRAC;
            for (int i = 0; i < NBUCKET; i++)
            begin
                if (est_rate(bkt_bytes[i], bkt_time[i], MSEC_SHIFT) >= wrate)
                begin
                    bkt_bytes[i] = (bkt_bytes[i] >= db) ? bkt_bytes[i] - db : '0;
                    bkt_time[i]  = (bkt_time[i] >= dt) ? bkt_time[i] - dt : '0;
                end
                else
                begin
                    bkt_bytes[i] += db;
                    bkt_time[i]  += dt;
                end
            end
            tot_bytes += win_bytes;
            tot_time  += win_time;
            win_bytes = '0;
            win_time  = '0;
            cached_req = '0;
            if (est_rate(tot_bytes, tot_time, SEC_SHIFT) <= 64'(m_default_tp))
                min_idx = '0;
            else
            begin
                m = m_raised_min >> UNIT;
                min_idx = (m >= NBUCKET) ? LOG_W'(NBUCKET - 1) : LOG_W'(m);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial clk = 0;
    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("FAIL adaptive_transfer_size_selector");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(15, 80);
    endfunction

    // ------------------------------------------------------------------
    // Driver: new transfer offered at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        xfer_t it;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_xfers.size() > 0)
            begin
                it = pending_xfers.pop_front();
                command       <= it.cmd;
                io_size       <= it.io;
                unit_io_size  <= it.unit;
                total_io_size <= it.total;
                elapsed_time  <= it.elapsed;
                in_valid      <= 1'b1;
                send_gap = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here
    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            recv_hold--;
            out_ready <= 1'b0;
        end
        else if (long_hold_req)
        begin
            long_hold_req = 0;
            recv_hold = 400;
            out_ready <= 1'b0;
        end
        else if (quiet_mode)
            out_ready <= 1'b1;
        else if (recv_stall > 0)
        begin
            recv_stall--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            recv_stall = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on accepted input, check accepted output
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [SIZE_W-1:0] want;
        in_taken <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            if (command == CMD_CHOOSE)
                chosen_sizes.push_back(choose_size(io_size));
            else
                fold_update(unit_io_size, total_io_size, elapsed_time);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (chosen_sizes.size() == 0)
                report_mismatch($sformatf("unexpected transfer_size %0d", transfer_size));
            else
            begin
                want = chosen_sizes.pop_front();
                if (transfer_size !== want)
                    report_mismatch($sformatf("transfer_size %0d, expected %0d",
                                              transfer_size, want));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_DEF_THROUGHPUT: m_default_tp = val[THR_W-1:0];
            CFG_SLOW_TERM:      m_slow_term  = val[TIME_W-1:0];
            CFG_STEP_BACK:      m_step_back  = val[SIZE_W-1:0];
            CFG_RAISED_MIN:     m_raised_min = val[SIZE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void add_choose(input logic [SIZE_W-1:0] req);
        xfer_t it;
        it.cmd = CMD_CHOOSE;
        it.io = req;
        it.unit = SIZE_W'($urandom);
        it.total = SIZE_W'($urandom);
        it.elapsed = TIME_W'({$urandom, $urandom});
        pending_xfers.push_back(it);
    endfunction

    function automatic void add_update(input logic [SIZE_W-1:0] unit,
                                       input logic [SIZE_W-1:0] total,
                                       input logic [TIME_W-1:0] elapsed);
        xfer_t it;
        it.cmd = CMD_UPDATE;
        it.io = SIZE_W'($urandom);
        it.unit = unit;
        it.total = total;
        it.elapsed = elapsed;
        pending_xfers.push_back(it);
    endfunction

    function automatic void add_random();
        int r;
        logic [SIZE_W-1:0] unit, total;
        logic [TIME_W-1:0] el;
        if ($urandom_range(0, 99) < 45)
        begin
            if ($urandom_range(0, 99) < 85)
                add_choose(SIZE_W'($urandom_range(0, 70000)));
            else
                add_choose(SIZE_W'($urandom));
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 82)
            unit = SIZE_W'((($urandom_range(0, NBUCKET - 1) + 1) << UNIT)
                           | $urandom_range(0, (1 << UNIT) - 1));
        else if (r < 91)
            unit = SIZE_W'($urandom_range(0, (1 << UNIT) - 1));
        else
            unit = SIZE_W'($urandom);
        total = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom)
                                            : SIZE_W'($urandom_range(0, 1 << 20));
        el = TIME_W'({$urandom, $urandom} >> $urandom_range(0, 63));
        add_update(unit, total, el);
    endfunction

    // Sender pauses here until every answer has come back and the block is quiet.
    task automatic drain();
        wait (pending_xfers.size() == 0 && !in_valid && chosen_sizes.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic random_batch(input int n);
        for (int i = 0; i < n; i++)
            add_random();
        drain();
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 0;
        out_ready = 0;
        command = CMD_CHOOSE;
        io_size = '0;
        unit_io_size = '0;
        total_io_size = '0;
        elapsed_time = '0;
        stats_reset();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: field extremes, cache hits, drops, slow term with step back
        add_choose('0);
        add_choose(SIZE_MAX);               // scans every bucket, caches top
        add_choose(24'd1023);               // below minimum
        add_choose(24'd1024);               // cached request is larger
        add_update(24'd1023, SIZE_MAX, '0); // small update, ignored
        add_update(SIZE_MAX, SIZE_MAX, '1); // bucket out of range, ignored
        add_update(24'd65536, 24'd4096, 40'd100);   // top bucket
        add_choose(24'd60000);
        add_update(24'd2048, SIZE_MAX, '1); // slow term, large cached choice steps back
        add_choose(24'd50000);
        add_choose(24'd60000);
        add_update(24'd1024, '0, 40'd2000000);      // slow term, cached choice steps back again
        add_choose(24'd3000);
        add_update(24'd1024, 24'd5, 40'd5);
        add_choose(24'd5000);
        add_choose(24'd4999);
        add_update(24'd40000, 24'd123456, '0);
        add_choose(24'd41000);
        drain();

        random_batch(380);

        // Extremes one way: everything low, raised minimum clamps
        cfg_write(CFG_DEF_THROUGHPUT, '0);
        cfg_write(CFG_SLOW_TERM, '0);
        cfg_write(CFG_STEP_BACK, '0);
        cfg_write(CFG_RAISED_MIN, CFG_DATA_W'(SIZE_MAX));
        random_batch(350);

        // Extremes the other way
        cfg_write(CFG_DEF_THROUGHPUT, CFG_DATA_W'(32'hFFFF_FFFF));
        cfg_write(CFG_SLOW_TERM, '1);
        cfg_write(CFG_STEP_BACK, CFG_DATA_W'(SIZE_MAX));
        cfg_write(CFG_RAISED_MIN, '0);
        random_batch(350);

        // Middle settings, spare index ignored, back-to-back traffic
        cfg_write(CFG_SPARE, '1);
        cfg_write(CFG_DEF_THROUGHPUT, 40'd1000);
        cfg_write(CFG_SLOW_TERM, 40'd5000);
        cfg_write(CFG_STEP_BACK, 40'd8192);
        cfg_write(CFG_RAISED_MIN, 40'd20000);
        quiet_mode = 1;
        random_batch(350);
        quiet_mode = 0;

        // Reset values again; long receiver hold while input keeps coming
        cfg_write(CFG_DEF_THROUGHPUT, CFG_DATA_W'(DEF_THROUGHPUT_RST));
        cfg_write(CFG_SLOW_TERM, CFG_DATA_W'(SLOW_TERM_RST));
        cfg_write(CFG_STEP_BACK, CFG_DATA_W'(STEP_BACK_RST));
        cfg_write(CFG_RAISED_MIN, CFG_DATA_W'(RAISED_MIN_RST));
        for (int i = 0; i < 40; i++)
            add_choose(SIZE_W'($urandom_range(0, 70000)));
        long_hold_req = 1;
        random_batch(400);

        if (chosen_sizes.size() != 0)
            report_mismatch($sformatf("%0d answers never arrived", chosen_sizes.size()));
        if (mismatches == 0)
            $display("PASS adaptive_transfer_size_selector");
        else
            $display("FAIL adaptive_transfer_size_selector");
        $finish;
    end

endmodule
